FILE: src/slsc_pkg.sv
`timescale 1ns / 1ps
package slsc_pkg;

  typedef enum logic [1:0] {
    REQ_INIT    = 2'd0,
    REQ_PROMOTE = 2'd1,
    REQ_PACE    = 2'd2,
    REQ_COMPARE = 2'd3
  } req_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_INIT,
    ST_SRCH_RD,
    ST_SRCH_EV,
    ST_MATCH_RD,
    ST_MATCH_EV,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_INSERT,
    ST_PACE,
    ST_CMP_DEF_L,
    ST_CMP_DEF_R,
    ST_CMP_RD_L,
    ST_CMP_RD_R,
    ST_CMP_EV,
    ST_CMP_LAST,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [63:0] cat;
    logic [1:0]  lvl;
    logic [7:0]  tim;
  } tag_t;

  localparam logic [3:0] LVL_NORM [4] = '{4'b0111, 4'b0110, 4'b0100, 4'b1111};
  localparam logic [3:0] LVL_HI   [4] = '{4'b1111, 4'b1110, 4'b1100, 4'b1000};

  function automatic logic lvl_ok(input logic hi, input logic [1:0] a,
                                  input logic [1:0] b);
    logic [3:0] row;
    row = hi ? LVL_HI[a] : LVL_NORM[a];
    return row[b];
  endfunction

endpackage

FILE: src/slsc_mem.sv
`timescale 1ns / 1ps
module slsc_mem
  import slsc_pkg::*;
#(
  parameter int DEPTH = 136,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  tag_t          wdata,
  input  logic [AW-1:0] raddr,
  output tag_t          rdata
);

  tag_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

FILE: src/security_label_store_compare.sv
`timescale 1ns / 1ps
// Label store built around one tag memory with one read and one write per cycle and a
// registered read. One request at a time. A compare walks both labels in merge steps, and
// each step consumes at least one listed tag. A promote does a binary search and then either
// replaces the tag, reports a full label, or inserts the tag; an insert moves the listed
// tags from the slot upward and the default tag up by one place. The result is held in an
// output register until taken, and no request is accepted while it waits.
module security_label_store_compare
  import slsc_pkg::*;
#(
  parameter int TAG_LIMIT_P = 16,
  parameter int NUM_LABELS  = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [2:0]  in_label_id,
  input  logic [2:0]  in_right_label,
  input  logic        in_hi_mode,
  input  logic [63:0] in_tag_category,
  input  logic [1:0]  in_tag_level,
  input  logic [7:0]  in_tag_time,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_status,
  output logic        out_leq_fails,
  output logic [7:0]  out_max_time
);

  localparam int SLOTS = TAG_LIMIT_P + 1;
  localparam int DEPTH = NUM_LABELS * SLOTS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(TAG_LIMIT_P + 1);
  localparam int LW    = $clog2(NUM_LABELS);
  localparam int XW    = CW + 1;

  state_t state_r, state_nxt;

  logic [LW-1:0] lab_r, rlab_r;
  req_t          req_r;
  logic          hi_r;
  tag_t          tag_r;
  logic [CW-1:0] cnt_r [NUM_LABELS];

  logic [XW-1:0] lo_r, up_r, idx_r, ri_r;
  logic [XW-1:0] lo_nxt, up_nxt, idx_nxt, ri_nxt;
  tag_t          ldef_r, ldef_nxt, rdef_r;
  tag_t          lcur_r, lcur_nxt;
  logic          fails_r, fails_nxt, status_r, status_nxt;
  logic [7:0]    tmax_r, tmax_nxt;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  tag_t          wdata, rdata;

  logic          ov_r;
  logic          ost_r, ofl_r;
  logic [7:0]    otm_r;

  logic          accept;
  logic [AW-1:0] lbase, rbase;
  logic [XW-1:0] lc, rc, mid;
  logic          lab_ok;

  // capture right default in the cycle after its read
  logic          rdef_cap_r;

  slsc_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign in_stall = (state_r != ST_IDLE) || ov_r;
  assign accept   = in_valid && !in_stall;
  assign lbase    = AW'(lab_r * SLOTS);
  assign rbase    = AW'(rlab_r * SLOTS);
  assign lc       = XW'(cnt_r[lab_r]);
  assign rc       = XW'(cnt_r[rlab_r]);
  assign mid      = XW'((lo_r + up_r) >> 1);
  assign lab_ok   = (XW'(in_label_id) < XW'(NUM_LABELS))
                 && ((in_req_type != REQ_COMPARE) || (XW'(in_right_label) < XW'(NUM_LABELS)));

  function automatic void pcheck(input tag_t a, input tag_t b, input logic hi,
                                 inout logic f, inout logic [7:0] m);
    if (!lvl_ok(hi, a.lvl, b.lvl)) f = 1'b1;
    if (a.tim > b.tim && a.tim > m) m = a.tim;
  endfunction

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:
        if (accept) begin
          if (!lab_ok) state_nxt = ST_DONE;
          else begin
            unique case (req_t'(in_req_type))
              REQ_INIT:    state_nxt = ST_INIT;
              REQ_PROMOTE: state_nxt = ST_SRCH_RD;
              REQ_PACE:    state_nxt = ST_PACE;
              REQ_COMPARE: state_nxt = ST_CMP_DEF_L;
            endcase
          end
        end
      ST_INIT:     state_nxt = ST_DONE;
      ST_SRCH_RD:  state_nxt = (up_r > lo_r) ? ST_SRCH_EV : ST_MATCH_RD;
      ST_SRCH_EV:  state_nxt = ST_SRCH_RD;
      ST_MATCH_RD: state_nxt = ST_MATCH_EV;
      ST_MATCH_EV: begin
        if (up_r < lc && rdata.cat == tag_r.cat) state_nxt = ST_DONE;
        else if (lc >= XW'(TAG_LIMIT_P)) state_nxt = ST_DONE;
        else state_nxt = ST_SHIFT_RD;
      end
      ST_SHIFT_RD: state_nxt = (idx_r > up_r) ? ST_SHIFT_WR : ST_INSERT;
      ST_SHIFT_WR: state_nxt = ST_SHIFT_RD;
      ST_INSERT:   state_nxt = ST_DONE;
      ST_PACE:     state_nxt = (idx_r > lc) ? ST_DONE : ST_PACE;
      ST_CMP_DEF_L: state_nxt = ST_CMP_DEF_R;
      ST_CMP_DEF_R: state_nxt = ST_CMP_RD_L;
      ST_CMP_RD_L:
        state_nxt = (idx_r < lc || ri_r < rc) ? ST_CMP_RD_R : ST_CMP_LAST;
      ST_CMP_RD_R: state_nxt = ST_CMP_EV;
      ST_CMP_EV:   state_nxt = ST_CMP_RD_L;
      ST_CMP_LAST: state_nxt = ST_DONE;
      ST_DONE:     state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    we = 1'b0;
    waddr = lbase;
    wdata = tag_r;
    raddr = lbase;
    lo_nxt = lo_r; up_nxt = up_r; idx_nxt = idx_r; ri_nxt = ri_r;
    ldef_nxt = ldef_r; lcur_nxt = lcur_r;
    fails_nxt = fails_r; tmax_nxt = tmax_r; status_nxt = status_r;
    unique case (state_r)
      ST_IDLE: begin
        lo_nxt = '0; idx_nxt = '0; ri_nxt = '0;
        up_nxt = XW'(cnt_r[in_label_id[LW-1:0]]);
        fails_nxt = 1'b0; tmax_nxt = '0; status_nxt = 1'b0;
      end
      ST_INIT: begin
        we = 1'b1;
        wdata = '{cat: '0, lvl: tag_r.lvl, tim: tag_r.tim};
      end
      ST_SRCH_RD: begin
        raddr = lbase + AW'(mid);
        idx_nxt = mid;
        if (!(up_r > lo_r)) raddr = lbase + AW'(up_r);
      end
      ST_SRCH_EV: begin
        if (tag_r.cat > rdata.cat) lo_nxt = idx_r + 1'b1;
        else up_nxt = idx_r;
      end
      ST_MATCH_RD: raddr = lbase + AW'(up_r);
      ST_MATCH_EV: begin
        if (up_r < lc && rdata.cat == tag_r.cat) begin
          we = 1'b1;
          waddr = lbase + AW'(up_r);
        end else if (lc >= XW'(TAG_LIMIT_P)) status_nxt = 1'b1;
        idx_nxt = lc + 1'b1;
      end
      ST_SHIFT_RD: raddr = lbase + AW'(idx_r - 1'b1);
      ST_SHIFT_WR: begin
        we = 1'b1;
        waddr = lbase + AW'(idx_r);
        wdata = rdata;
        idx_nxt = idx_r - 1'b1;
      end
      ST_INSERT: begin
        we = 1'b1;
        waddr = lbase + AW'(up_r);
      end
      ST_PACE: begin
        if (idx_r <= lc) raddr = lbase + AW'(idx_r);
        if (idx_r != '0) begin
          we = 1'b1;
          waddr = lbase + AW'(idx_r - 1'b1);
          wdata = rdata;
          wdata.tim = '0;
        end
        idx_nxt = idx_r + 1'b1;
      end
      ST_CMP_DEF_L: raddr = lbase + AW'(lc);
      ST_CMP_DEF_R: begin
        ldef_nxt = rdata;
        raddr = rbase + AW'(rc);
      end
      ST_CMP_RD_L: raddr = lbase + AW'(idx_r);
      ST_CMP_RD_R: begin
        lcur_nxt = rdata;
        raddr = rbase + AW'(ri_r);
      end
      ST_CMP_EV: begin
        if (idx_r >= lc) begin
          pcheck(ldef_r, rdata, hi_r, fails_nxt, tmax_nxt);
          ri_nxt = ri_r + 1'b1;
        end else if (ri_r >= rc) begin
          pcheck(lcur_r, rdef_r, hi_r, fails_nxt, tmax_nxt);
          idx_nxt = idx_r + 1'b1;
        end else if (lcur_r.cat == rdata.cat) begin
          pcheck(lcur_r, rdata, hi_r, fails_nxt, tmax_nxt);
          idx_nxt = idx_r + 1'b1;
          ri_nxt = ri_r + 1'b1;
        end else if (lcur_r.cat < rdata.cat) begin
          pcheck(lcur_r, rdef_r, hi_r, fails_nxt, tmax_nxt);
          idx_nxt = idx_r + 1'b1;
        end else begin
          pcheck(ldef_r, rdata, hi_r, fails_nxt, tmax_nxt);
          ri_nxt = ri_r + 1'b1;
        end
      end
      ST_CMP_LAST: pcheck(ldef_r, rdef_r, hi_r, fails_nxt, tmax_nxt);
      ST_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r <= 1'b0;
      rdef_cap_r <= 1'b0;
      for (int i = 0; i < NUM_LABELS; i++) cnt_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      rdef_cap_r <= (state_r == ST_CMP_DEF_R);
      if (state_r == ST_DONE) ov_r <= 1'b1;
      else if (ov_r && !out_stall) ov_r <= 1'b0;
      if (state_r == ST_INIT) cnt_r[lab_r] <= '0;
      if (state_r == ST_INSERT) cnt_r[lab_r] <= CW'(lc + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r  <= req_t'(in_req_type);
      lab_r  <= in_label_id[LW-1:0];
      rlab_r <= in_right_label[LW-1:0];
      hi_r   <= in_hi_mode;
      tag_r  <= '{cat: in_tag_category, lvl: in_tag_level, tim: in_tag_time};
    end
    lo_r <= lo_nxt; up_r <= up_nxt; idx_r <= idx_nxt; ri_r <= ri_nxt;
    ldef_r <= ldef_nxt; lcur_r <= lcur_nxt;
    if (rdef_cap_r) rdef_r <= rdata;
    fails_r <= fails_nxt; tmax_r <= tmax_nxt; status_r <= status_nxt;
    if (state_r == ST_DONE) begin
      ost_r <= status_r && (req_r == REQ_PROMOTE);
      ofl_r <= fails_r;
      otm_r <= tmax_r;
    end
  end

  assign out_valid     = ov_r;
  assign out_status    = ost_r;
  assign out_leq_fails = ofl_r;
  assign out_max_time  = otm_r;

endmodule

FILE: src/slsc_checker.sv
`timescale 1ns / 1ps
module slsc_sva (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_status,
  input logic       out_leq_fails,
  input logic [7:0] out_max_time
);

  a_one_at_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall) else $error("request taken while busy");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_max_time))
    else $error("result dropped");

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> !out_leq_fails && out_max_time == 8'd0)
    else $error("status with compare result");

  a_stall_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input open while result pending");

endmodule

bind security_label_store_compare slsc_sva u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall),
  .out_status(out_status), .out_leq_fails(out_leq_fails), .out_max_time(out_max_time)
);

FILE: sim/slsc_checker.sv
`timescale 1ns / 1ps
module slsc_checker
  import slsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [2:0]  in_label_id,
  input  logic [2:0]  in_right_label,
  input  logic        in_hi_mode,
  input  logic [63:0] in_tag_category,
  input  logic [1:0]  in_tag_level,
  input  logic [7:0]  in_tag_time,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_status,
  input  logic        out_leq_fails,
  input  logic [7:0]  out_max_time,
  output int          fail_count,
  output int          pending
);

  localparam int MAX_TAGS = 16;
  localparam int SLOT_CNT = MAX_TAGS + 1;

  typedef struct packed {
    logic       status;
    logic       fails;
    logic [7:0] tmax;
  } answer_t;

  logic [63:0] cat_mem [8][SLOT_CNT];
  logic [1:0]  lvl_mem [8][SLOT_CNT];
  logic [7:0]  tim_mem [8][SLOT_CNT];
  int          tag_cnt [8];
  answer_t     answers_due [$];

  function automatic bit level_ordered(bit hi, logic [1:0] a, logic [1:0] b);
    if (hi) return a <= b;
    return (a == 2'd3) || (b != 2'd3 && a <= b);
  endfunction

  task automatic check_pair(int l, int li, int r, int ri, bit hi, inout answer_t ans);
    if (!level_ordered(hi, lvl_mem[l][li], lvl_mem[r][ri])) ans.fails = 1'b1;
    if (tim_mem[l][li] > tim_mem[r][ri] && tim_mem[l][li] > ans.tmax)
      ans.tmax = tim_mem[l][li];
  endtask

  task automatic merge_labels(int l, int r, bit hi, inout answer_t ans);
    int li, ri, lc, rc;
    li = 0;
    ri = 0;
    lc = tag_cnt[l];
    rc = tag_cnt[r];
    while (li < lc || ri < rc) begin
      if (li >= lc) begin
        check_pair(l, lc, r, ri, hi, ans);
        ri++;
      end else if (ri >= rc) begin
        check_pair(l, li, r, rc, hi, ans);
        li++;
      end else if (cat_mem[l][li] == cat_mem[r][ri]) begin
        check_pair(l, li, r, ri, hi, ans);
        li++;
        ri++;
      end else if (cat_mem[l][li] < cat_mem[r][ri]) begin
        check_pair(l, li, r, rc, hi, ans);
        li++;
      end else begin
        check_pair(l, lc, r, ri, hi, ans);
        ri++;
      end
    end
    check_pair(l, lc, r, rc, hi, ans);
  endtask

  function automatic logic promote_tag(int lab, logic [63:0] cat, logic [1:0] lvl,
                                       logic [7:0] tim);
    int lo, up, mid, cnt;
    cnt = tag_cnt[lab];
    lo = 0;
    up = cnt;
    while (up > lo) begin
      mid = (lo + up) / 2;
      if (cat > cat_mem[lab][mid]) lo = mid + 1;
      else up = mid;
    end
    if (up < cnt && cat_mem[lab][up] == cat) begin
      lvl_mem[lab][up] = lvl;
      tim_mem[lab][up] = tim;
      return 1'b0;
    end
    if (cnt >= MAX_TAGS) return 1'b1;
    for (int i = cnt + 1; i > up; i--) begin
      cat_mem[lab][i] = cat_mem[lab][i-1];
      lvl_mem[lab][i] = lvl_mem[lab][i-1];
      tim_mem[lab][i] = tim_mem[lab][i-1];
    end
    cat_mem[lab][up] = cat;
    lvl_mem[lab][up] = lvl;
    tim_mem[lab][up] = tim;
    tag_cnt[lab] = cnt + 1;
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    answer_t ans;
    answer_t want;
    int lab;
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) tag_cnt[i] = 0;
      answers_due.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        ans = '0;
        lab = in_label_id;
        case (req_t'(in_req_type))
          REQ_INIT: begin
            tag_cnt[lab] = 0;
            cat_mem[lab][0] = '0;
            lvl_mem[lab][0] = in_tag_level;
            tim_mem[lab][0] = in_tag_time;
          end
          REQ_PROMOTE: ans.status = promote_tag(lab, in_tag_category, in_tag_level,
                                                in_tag_time);
          REQ_PACE: for (int i = 0; i <= tag_cnt[lab]; i++) tim_mem[lab][i] = '0;
          REQ_COMPARE: merge_labels(lab, in_right_label, in_hi_mode, ans);
        endcase
        answers_due.push_back(ans);
      end
      if (out_valid && !out_stall) begin
        if (answers_due.size() == 0) begin
          if (fail_count < 10) $display("unexpected result at %0t", $realtime);
          fail_count <= fail_count + 1;
        end else begin
          want = answers_due.pop_front();
          if (want.status !== out_status || want.fails !== out_leq_fails ||
              want.tmax !== out_max_time) begin
            if (fail_count < 10)
              $display({"mismatch at %0t: expected status %0d fails %0d max_time %0d,",
                        " got status %0d fails %0d max_time %0d"},
                       $realtime, want.status, want.fails, want.tmax,
                       out_status, out_leq_fails, out_max_time);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= answers_due.size();
    end
  end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
module tb_top
  import slsc_pkg::*;
();

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_req_type = '0;
  logic [2:0]  in_label_id = '0;
  logic [2:0]  in_right_label = '0;
  logic        in_hi_mode = 1'b0;
  logic [63:0] in_tag_category = '0;
  logic [1:0]  in_tag_level = '0;
  logic [7:0]  in_tag_time = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_status;
  logic        out_leq_fails;
  logic [7:0]  out_max_time;
  int          fail_count;
  int          pending;
  int          cycle_count = 0;
  int          sent = 0;
  bit          label_ready [8];
  logic [63:0] cat_pool [24];

  always #10 clk = ~clk;

  security_label_store_compare DUT (.*);
  slsc_checker checker_i (.*);

  function automatic bit quiet_stretch();
    return sent >= 700 && sent < 1000;
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    out_stall <= quiet_stretch() ? 1'b0 : ($urandom_range(99) < 21);
    if (cycle_count > 2000000) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_request(req_t req, int lab, int rlab, bit hi, logic [63:0] cat,
                              logic [1:0] lvl, logic [7:0] tim);
    while (!quiet_stretch() && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_label_id <= 3'(lab);
    in_right_label <= 3'(rlab);
    in_hi_mode <= hi;
    in_tag_category <= cat;
    in_tag_level <= lvl;
    in_tag_time <= tim;
    if (req == REQ_INIT) label_ready[lab] = 1'b1;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  function automatic int pick_label();
    int lab;
    do lab = $urandom_range(7); while (!label_ready[lab]);
    return lab;
  endfunction

  initial begin
    int lab;
    int roll;
    logic [63:0] cat;
    for (int i = 0; i < 24; i++) cat_pool[i] = {$urandom, $urandom};
    cat_pool[0] = '0;
    cat_pool[1] = '1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < 8; i++)
      send_request(REQ_INIT, i, 0, 0, '1, i[1:0], (i % 2) ? 8'hff : 8'h00);
    send_request(REQ_PROMOTE, 1, 0, 0, '0, 2'd3, 8'hff);
    send_request(REQ_PROMOTE, 1, 0, 0, '1, 2'd0, 8'h01);
    send_request(REQ_PROMOTE, 1, 0, 0, '1, 2'd2, 8'h80);
    send_request(REQ_PROMOTE, 2, 0, 0, 64'h8000_0000_0000_0000, 2'd1, 8'h7f);
    send_request(REQ_COMPARE, 1, 2, 0, '0, 2'd0, 8'h00);
    send_request(REQ_COMPARE, 1, 2, 1, '0, 2'd0, 8'h00);
    send_request(REQ_COMPARE, 2, 1, 1, '0, 2'd0, 8'h00);
    send_request(REQ_COMPARE, 1, 1, 0, '0, 2'd0, 8'h00);
    send_request(REQ_COMPARE, 3, 6, 0, '0, 2'd0, 8'h00);
    send_request(REQ_PACE, 1, 0, 0, '0, 2'd0, 8'h00);
    send_request(REQ_COMPARE, 2, 1, 0, '0, 2'd0, 8'h00);
    send_request(REQ_PACE, 4, 0, 0, '0, 2'd0, 8'h00);

    for (int n = 0; n < 1600; n++) begin
      roll = $urandom_range(99);
      lab = pick_label();
      cat = ($urandom_range(9) == 0) ? {$urandom, $urandom} : cat_pool[$urandom_range(23)];
      if (roll < 5)
        send_request(REQ_INIT, $urandom_range(7), $urandom_range(7), 1'($urandom_range(1)),
                     {$urandom, $urandom}, 2'($urandom_range(3)), 8'($urandom_range(255)));
      else if (roll < 58)
        send_request(REQ_PROMOTE, lab, $urandom_range(7), 1'($urandom_range(1)), cat,
                     2'($urandom_range(3)), 8'($urandom_range(255)));
      else if (roll < 65)
        send_request(REQ_PACE, lab, $urandom_range(7), 1'($urandom_range(1)),
                     {$urandom, $urandom}, 2'($urandom_range(3)), 8'($urandom_range(255)));
      else
        send_request(REQ_COMPARE, lab, pick_label(), 1'($urandom_range(1)),
                     {$urandom, $urandom}, 2'($urandom_range(3)), 8'($urandom_range(255)));
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

FILE: files.f
src/slsc_pkg.sv
src/slsc_mem.sv
src/security_label_store_compare.sv
src/slsc_checker.sv
sim/slsc_checker.sv
sim/tb_top.sv
